### rtl/servo_move_interpolator_assert.svh
// Assertion macros for the servo move interpolator RTL, included by smi_front.
`ifndef SERVO_MOVE_INTERPOLATOR_ASSERT_SVH
`define SERVO_MOVE_INTERPOLATOR_ASSERT_SVH

// Property holds at every clock edge outside reset.
`define SMI_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked during reset as well.
`define SMI_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/smi_pkg.sv
// Package: constants, types and helpers for the servo move interpolator.
package smi_pkg;
   localparam int JOINTS = 3;
   localparam int ANG_W = 10;
   localparam int TIME_W = 16;
   localparam int TICK_W = 10;
   localparam int PULSE_W = 12;
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_MOVE = 1'b1;
   localparam logic [0:0] REG_MIRROR = 1'b0;
   localparam int QDEPTH = 2;

   // Command word passed from front end to back end.
   typedef struct packed {
      logic cmd;
      logic [TICK_W-1:0] tick_ms;
      logic signed [ANG_W-1:0] goal0;
      logic signed [ANG_W-1:0] goal1;
      logic signed [ANG_W-1:0] goal2;
      logic [TIME_W-1:0] move_ms;
   } cmd_word_type;

   // Reset angle of a joint: joint 1 rests at 0, the others at 90.
   function automatic logic signed [ANG_W-1:0] rest_angle(input int j);
      rest_angle = (j == 1) ? ANG_W'(0) : ANG_W'(90);
   endfunction
endpackage

### rtl/smi_front.sv
// Front end: accepts command words into a short queue.
module smi_front (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  smi_pkg::cmd_word_type push_word,
   output logic q_valid,
   input  logic q_take,
   output smi_pkg::cmd_word_type q_word
);
   import smi_pkg::*;

   cmd_word_type mem_ff [QDEPTH];
   logic [0:0] wr_ff, rd_ff, wr_in, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign full = (cnt_ff == 2'(QDEPTH));
   assign q_valid = (cnt_ff != 2'd0);
   assign q_word = mem_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop = q_take && q_valid;

   // Pointer and count update
   always_comb begin
      wr_in = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_word;
   end

   `include "servo_move_interpolator_assert.svh"
   `SMI_ASSERT(a_cnt_range, clock, reset, cnt_ff <= 2'(QDEPTH), "queue count overflow")
   `SMI_ASSERT(a_cnt_track, clock, reset,
      (do_push && !do_pop) |=> cnt_ff == $past(cnt_ff) + 2'd1, "count missed push")
   `SMI_ASSERT(a_ptr_sync, clock, reset,
      (cnt_ff == 2'd0 || cnt_ff == 2'(QDEPTH)) |-> wr_ff == rd_ff, "pointer mismatch")
endmodule

### rtl/smi_div.sv
// Restoring divider: unsigned 33-bit dividend by 16-bit divisor, one bit a cycle.
module smi_div (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [32:0] dividend,
   input  logic [15:0] divisor,
   output logic busy,
   output logic [32:0] quot
);
   logic [32:0] q_ff, q_in;
   logic [16:0] r_ff, r_in;
   logic [15:0] d_ff, d_in;
   logic [5:0] n_ff, n_in;
   logic [16:0] sh;

   assign busy = (n_ff != 6'd0);
   assign quot = q_ff;
   assign sh = {r_ff[15:0], q_ff[32]};

   // One quotient bit per cycle
   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      n_in = n_ff;
      if (start) begin
         q_in = dividend;
         r_in = '0;
         d_in = divisor;
         n_in = 6'd33;
      end else if (busy) begin
         n_in = n_ff - 6'd1;
         if (sh >= {1'b0, d_ff}) begin
            r_in = sh - {1'b0, d_ff};
            q_in = {q_ff[31:0], 1'b1};
         end else begin
            r_in = sh;
            q_in = {q_ff[31:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) n_ff <= '0;
      else n_ff <= n_in;
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end
endmodule

### rtl/smi_back.sv
// Back end: updates joint state and computes pulses one joint at a time.
module smi_back (
   input  logic clock,
   input  logic reset,
   input  logic mirror,
   input  logic q_valid,
   output logic q_take,
   input  smi_pkg::cmd_word_type q_word,
   output logic rsp_empty,
   input  logic rsp_pop,
   output logic [smi_pkg::PULSE_W-1:0] rsp_pulse_joint0,
   output logic [smi_pkg::PULSE_W-1:0] rsp_pulse_joint1,
   output logic [smi_pkg::PULSE_W-1:0] rsp_pulse_joint2,
   output logic rsp_all_done
);
   import smi_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOAD = 3'd1;
   localparam logic [2:0] ST_DIV1 = 3'd2;
   localparam logic [2:0] ST_DIV2 = 3'd3;
   localparam logic [2:0] ST_PULSE = 3'd4;
   localparam logic [2:0] ST_NEXT = 3'd5;
   localparam logic [2:0] ST_OUT = 3'd6;
   localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

   logic [2:0] st_ff, st_in;
   logic [JW-1:0] j_ff, j_in;
   logic signed [ANG_W-1:0] start_ff [JOINTS];
   logic signed [ANG_W-1:0] targ_ff [JOINTS];
   logic [TIME_W-1:0] el_ff [JOINTS];
   logic [TIME_W-1:0] dur_ff [JOINTS];
   cmd_word_type w_ff;
   logic done_ff;
   logic signed [15:0] ang_ff;
   logic signed [33:0] acc_ff;
   logic neg_ff;
   logic [PULSE_W-1:0] pulse_ff [3];
   logic [PULSE_W-1:0] outp_ff [3];
   logic out_valid_ff, outd_ff;

   // Joint arithmetic
   logic [TIME_W:0] e_sum;
   logic signed [ANG_W:0] delta;
   logic signed [33:0] num1, num2, dvd;
   logic signed [15:0] ma;
   logic [15:0] ma_mag;
   logic [10:0] ma_clip;
   logic [29:0] recip_prod;
   logic [12:0] pq;
   logic div_start, div_busy;
   logic [32:0] div_q, dvd_mag;
   logic [15:0] div_d;
   logic signed [33:0] sq;
   logic signed [14:0] pulse_full;

   assign e_sum = {1'b0, el_ff[j_ff]} + (TIME_W+1)'(w_ff.tick_ms);
   assign delta = ANG_W'(targ_ff[j_ff]) - ANG_W'(start_ff[j_ff]);
   assign num1 = 34'(start_ff[j_ff]) * 34'($signed({1'b0, dur_ff[j_ff]}))
                 + 34'(delta) * 34'($signed({1'b0, e_sum[TIME_W-1:0]}));
   assign num2 = 34'(delta) * 34'($signed({1'b0, w_ff.tick_ms}));
   assign sq = neg_ff ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
   assign dvd_mag = dvd[33] ? 33'(-dvd) : 33'(dvd);

   // Pulse conversion: a*512/180 = a*128/45, floor(x/45) by reciprocal multiply.
   // Magnitudes past 1440 saturate either way, so the operand is clipped there.
   assign ma = mirror ? 16'sd180 - ang_ff : ang_ff;
   assign ma_mag = ma[15] ? 16'(-ma) : 16'(ma);
   assign ma_clip = (ma_mag > 16'd1440) ? 11'd1440 : ma_mag[10:0];
   assign recip_prod = 30'(ma_clip) * 30'd372828;
   assign pq = recip_prod[29:17];
   assign pulse_full = ma[15] ? 15'sd128 - $signed({2'b0, pq})
                              : 15'sd128 + $signed({2'b0, pq});

   smi_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(dvd_mag),
      .divisor(div_d), .busy(div_busy), .quot(div_q)
   );

   assign rsp_empty = !out_valid_ff;
   assign rsp_pulse_joint0 = outp_ff[0];
   assign rsp_pulse_joint1 = outp_ff[1];
   assign rsp_pulse_joint2 = outp_ff[2];
   assign rsp_all_done = outd_ff;
   assign q_take = (st_ff == ST_IDLE) && q_valid;

   // Sequencer next state and divider launch
   always_comb begin
      st_in = st_ff;
      j_in = j_ff;
      div_start = 1'b0;
      dvd = num1;
      div_d = dur_ff[j_ff];
      case (st_ff)
         ST_IDLE: begin
            if (q_valid) begin
               st_in = (q_word.cmd == CMD_MOVE) ? ST_IDLE : ST_LOAD;
               j_in = '0;
            end
         end
         ST_LOAD: begin
            if (e_sum >= {1'b0, dur_ff[j_ff]}) begin
               st_in = ST_PULSE;
            end else begin
               st_in = ST_DIV1;
               div_start = 1'b1;
            end
         end
         ST_DIV1: if (!div_busy) begin
            st_in = ST_DIV2;
            dvd = num2;
            div_start = 1'b1;
         end
         ST_DIV2: if (!div_busy) st_in = ST_PULSE;
         ST_PULSE: st_in = ST_NEXT;
         ST_NEXT: begin
            if (32'(j_ff) == JOINTS - 1) st_in = ST_OUT;
            else begin
               j_in = j_ff + 1'b1;
               st_in = ST_LOAD;
            end
         end
         ST_OUT: if (!out_valid_ff || rsp_pop) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         j_ff <= '0;
         out_valid_ff <= 1'b0;
         for (int j = 0; j < JOINTS; j++) begin
            start_ff[j] <= rest_angle(j);
            targ_ff[j] <= rest_angle(j);
            el_ff[j] <= '0;
            dur_ff[j] <= '0;
         end
      end else begin
         st_ff <= st_in;
         j_ff <= j_in;
         // Output word loads in ST_OUT, clears when popped
         if (st_ff == ST_OUT && (!out_valid_ff || rsp_pop)) out_valid_ff <= 1'b1;
         else if (rsp_pop && out_valid_ff) out_valid_ff <= 1'b0;
         case (st_ff)
            ST_IDLE: begin
               w_ff <= q_word;
               done_ff <= 1'b1;
               if (q_valid && q_word.cmd == CMD_MOVE) begin
                  for (int j = 0; j < JOINTS; j++) begin
                     start_ff[j] <= targ_ff[j];
                     el_ff[j] <= '0;
                     dur_ff[j] <= q_word.move_ms;
                  end
                  targ_ff[0] <= q_word.goal0;
                  if (JOINTS > 1) targ_ff[1 % JOINTS] <= q_word.goal1;
                  if (JOINTS > 2) targ_ff[2 % JOINTS] <= q_word.goal2;
               end
            end
            ST_LOAD: begin
               if (e_sum >= {1'b0, dur_ff[j_ff]}) begin
                  el_ff[j_ff] <= dur_ff[j_ff];
                  ang_ff <= 16'(targ_ff[j_ff]);
               end else begin
                  el_ff[j_ff] <= e_sum[TIME_W-1:0];
                  neg_ff <= num1[33];
                  done_ff <= 1'b0;
               end
            end
            ST_DIV1: if (!div_busy) begin
               acc_ff <= sq;
               neg_ff <= num2[33];
            end
            ST_DIV2: if (!div_busy) begin
               ang_ff <= 16'(acc_ff + sq);
            end
            ST_PULSE: begin
               if (pulse_full < 0) pulse_ff[j_ff] <= '0;
               else if (pulse_full > 15'sd4095) pulse_ff[j_ff] <= '1;
               else pulse_ff[j_ff] <= PULSE_W'(pulse_full);
            end
            ST_OUT: if (!out_valid_ff || rsp_pop) begin
               outp_ff[0] <= pulse_ff[0];
               outp_ff[1] <= (JOINTS > 1) ? pulse_ff[1] : '0;
               outp_ff[2] <= (JOINTS > 2) ? pulse_ff[2] : '0;
               outd_ff <= done_ff;
            end
            default: ;
         endcase
      end
   end
endmodule

### rtl/servo_move_interpolator.sv
// A tick word is worked one joint at a time: a joint at its target goes through LOAD,
// PULSE and NEXT; a moving joint also runs two serial divisions (DIV1, DIV2).
// The back end takes one word at a time; a tick's result waits in ST_OUT while an
// unread result word blocks the output.
// A two-word queue takes new words while the back end works.
// Synchronous active-high reset: angles 90, 0, 90; times zero; mirror off.
module servo_move_interpolator (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  logic req_cmd,
   input  logic [smi_pkg::TICK_W-1:0] req_tick_ms,
   input  logic signed [smi_pkg::ANG_W-1:0] req_goal_joint0,
   input  logic signed [smi_pkg::ANG_W-1:0] req_goal_joint1,
   input  logic signed [smi_pkg::ANG_W-1:0] req_goal_joint2,
   input  logic [smi_pkg::TIME_W-1:0] req_move_ms,
   output logic rsp_empty,
   input  logic rsp_pop,
   output logic [smi_pkg::PULSE_W-1:0] rsp_pulse_joint0,
   output logic [smi_pkg::PULSE_W-1:0] rsp_pulse_joint1,
   output logic [smi_pkg::PULSE_W-1:0] rsp_pulse_joint2,
   output logic rsp_all_done,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [0:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   import smi_pkg::*;

   cmd_word_type push_word, q_word;
   logic q_valid, q_take;
   logic mirror_ff;

   assign push_word = '{cmd: req_cmd, tick_ms: req_tick_ms, goal0: req_goal_joint0,
      goal1: req_goal_joint1, goal2: req_goal_joint2, move_ms: req_move_ms};

   // Register port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_MIRROR) ? {31'd0, mirror_ff} : '0;
   always_ff @(posedge clock) begin
      if (reset) mirror_ff <= 1'b0;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == REG_MIRROR)
         mirror_ff <= csr_pwdata[0];
   end

   smi_front u_front (
      .clock(clock), .reset(reset), .push(req_push), .full(req_full),
      .push_word(push_word), .q_valid(q_valid), .q_take(q_take), .q_word(q_word)
   );

   smi_back u_back (
      .clock(clock), .reset(reset), .mirror(mirror_ff), .q_valid(q_valid),
      .q_take(q_take), .q_word(q_word), .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_pulse_joint0(rsp_pulse_joint0), .rsp_pulse_joint1(rsp_pulse_joint1),
      .rsp_pulse_joint2(rsp_pulse_joint2), .rsp_all_done(rsp_all_done)
   );
endmodule

### dv/testbench.sv
// Self-checking testbench for the servo move interpolator: queue-driven stimulus, predicted pulses.
`timescale 1ns / 1ps

module testbench;
   import smi_pkg::*;

   // One command word as sent to the block.
   typedef struct packed {
      logic cmd;
      logic [TICK_W-1:0] tick_ms;
      logic signed [ANG_W-1:0] goal0;
      logic signed [ANG_W-1:0] goal1;
      logic signed [ANG_W-1:0] goal2;
      logic [TIME_W-1:0] move_ms;
   } servo_word_type;

   // One pulse word expected back per tick.
   typedef struct packed {
      logic [PULSE_W-1:0] p0;
      logic [PULSE_W-1:0] p1;
      logic [PULSE_W-1:0] p2;
      logic done;
   } pulse_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic req_cmd = CMD_TICK;
   logic [TICK_W-1:0] req_tick_ms = '0;
   logic signed [ANG_W-1:0] req_goal_joint0 = '0;
   logic signed [ANG_W-1:0] req_goal_joint1 = '0;
   logic signed [ANG_W-1:0] req_goal_joint2 = '0;
   logic [TIME_W-1:0] req_move_ms = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic [PULSE_W-1:0] rsp_pulse_joint0;
   logic [PULSE_W-1:0] rsp_pulse_joint1;
   logic [PULSE_W-1:0] rsp_pulse_joint2;
   logic rsp_all_done;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [0:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   servo_move_interpolator dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor state
   logic signed [ANG_W-1:0] joint_start [JOINTS];
   logic signed [ANG_W-1:0] joint_target [JOINTS];
   logic [TIME_W-1:0] joint_elapsed [JOINTS];
   logic [TIME_W-1:0] joint_dur [JOINTS];
   bit mirror_on;

   servo_word_type word_queue [$];
   pulse_word_type pulse_queue [$];
   int errors = 0;
   int ticks_checked = 0;
   int moves_sent = 0;
   bit idle_on = 1'b1;

   // Gap length: mostly none or short, now and then long.
   function automatic int next_gap();
      int r;
      r = $urandom_range(99);
      if (!idle_on || r < 55) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // Advance the joint model by one word; ticks yield an expected pulse word.
   task automatic apply_word(input servo_word_type w);
      logic signed [ANG_W-1:0] goals [JOINTS];
      longint e, s, d, dl, a, p;
      logic [PULSE_W-1:0] pv [JOINTS];
      bit done;
      goals[0] = w.goal0;
      goals[1] = w.goal1;
      goals[2] = w.goal2;
      if (w.cmd == CMD_MOVE) begin
         moves_sent++;
         for (int j = 0; j < JOINTS; j++) begin
            joint_start[j] = joint_target[j];
            joint_target[j] = goals[j];
            joint_dur[j] = w.move_ms;
            joint_elapsed[j] = '0;
         end
         return;
      end
      done = 1'b1;
      for (int j = 0; j < JOINTS; j++) begin
         e = longint'(joint_elapsed[j]) + longint'(w.tick_ms);
         if (e >= longint'(joint_dur[j])) begin
            joint_elapsed[j] = joint_dur[j];
            a = joint_target[j];
         end else begin
            joint_elapsed[j] = e[TIME_W-1:0];
            s = joint_start[j];
            d = joint_dur[j];
            dl = longint'(joint_target[j]) - s;
            // position now plus one tick of lookahead
            a = (s * d + dl * e) / d + (dl * longint'(w.tick_ms)) / d;
         end
         if (mirror_on) a = 180 - a;
         p = 128 + (a * 512) / 180;
         if (p < 0) p = 0;
         if (p > 4095) p = 4095;
         pv[j] = p[PULSE_W-1:0];
         if (joint_elapsed[j] < joint_dur[j]) done = 1'b0;
      end
      pulse_queue.push_back('{pv[0], pv[1], pv[2], done});
   endtask

   // Driver: push words from the queue with random gaps.
   int push_gap = 0;
   always @(posedge clock) begin
      servo_word_type w;
      bit taken;
      taken = req_push && !req_full;
      if (taken) begin
         apply_word(word_queue.pop_front());
         push_gap = next_gap();
      end
      if (req_push && !taken) begin
         // hold the word until accepted
      end else if (reset || push_gap > 0 || word_queue.size() == 0) begin
         if (push_gap > 0 && !reset) push_gap--;
         req_push <= 1'b0;
      end else begin
         w = word_queue[0];
         req_push <= 1'b1;
         req_cmd <= w.cmd;
         req_tick_ms <= w.tick_ms;
         req_goal_joint0 <= w.goal0;
         req_goal_joint1 <= w.goal1;
         req_goal_joint2 <= w.goal2;
         req_move_ms <= w.move_ms;
      end
   end

   // Monitor: pop with random stalls and check each pulse word.
   int pop_stall = 0;
   always @(posedge clock) begin
      pulse_word_type x;
      if (!reset && rsp_pop && !rsp_empty) begin
         ticks_checked++;
         if (pulse_queue.size() == 0) begin
            $display("%0t: unexpected word p0=%0d p1=%0d p2=%0d done=%0d", $time,
                     rsp_pulse_joint0, rsp_pulse_joint1, rsp_pulse_joint2, rsp_all_done);
            errors++;
         end else begin
            x = pulse_queue.pop_front();
            if (rsp_pulse_joint0 !== x.p0) begin
               $display("%0t: pulse_joint0 expected %0d actual %0d", $time, x.p0,
                        rsp_pulse_joint0);
               errors++;
            end
            if (rsp_pulse_joint1 !== x.p1) begin
               $display("%0t: pulse_joint1 expected %0d actual %0d", $time, x.p1,
                        rsp_pulse_joint1);
               errors++;
            end
            if (rsp_pulse_joint2 !== x.p2) begin
               $display("%0t: pulse_joint2 expected %0d actual %0d", $time, x.p2,
                        rsp_pulse_joint2);
               errors++;
            end
            if (rsp_all_done !== x.done) begin
               $display("%0t: all_done expected %0d actual %0d", $time, x.done,
                        rsp_all_done);
               errors++;
            end
         end
         pop_stall = next_gap();
      end
      if (pop_stall > 0) begin
         pop_stall--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= !reset;
      end
   end

   function automatic servo_word_type tick_word(input int ms);
      return '{CMD_TICK, ms[TICK_W-1:0], '0, '0, '0, '0};
   endfunction

   function automatic servo_word_type move_word(input int g0, input int g1, input int g2,
                                                input int ms);
      return '{CMD_MOVE, TICK_W'($urandom), g0[ANG_W-1:0], g1[ANG_W-1:0], g2[ANG_W-1:0],
               ms[TIME_W-1:0]};
   endfunction

   function automatic int rand_goal();
      if ($urandom_range(9) == 0) return $urandom_range(1023) - 512;
      return $urandom_range(540) - 180;
   endfunction

   // Wait until every word is in and answered, then let the back end drain.
   task automatic wait_idle();
      while (word_queue.size() != 0 || req_push || pulse_queue.size() != 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // APB write of the mirror register: setup then access.
   task automatic write_mirror(input bit v);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= REG_MIRROR;
      csr_pwdata <= {31'd0, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      mirror_on = v;
   endtask

   // Random part: moves followed by a run of ticks, plus some stray ticks.
   task automatic random_phase(input int n);
      int cnt, k, dur;
      cnt = 0;
      while (cnt < n) begin
         if ($urandom_range(9) == 0) begin
            word_queue.push_back(tick_word($urandom_range(1023)));
            cnt++;
         end else begin
            case ($urandom_range(9))
               0: dur = 0;
               1: dur = $urandom_range(65535, 20000);
               default: dur = $urandom_range(3000, 1);
            endcase
            word_queue.push_back(move_word(rand_goal(), rand_goal(), rand_goal(), dur));
            k = $urandom_range(8, 1);
            for (int i = 0; i < k; i++)
               word_queue.push_back(tick_word($urandom_range(9) == 0 ? 1023 :
                                              $urandom_range(dur > 1000 ? 1000 : dur)));
            cnt += k + 1;
         end
      end
   endtask

   initial begin
      for (int j = 0; j < JOINTS; j++) begin
         joint_start[j] = (j == 1) ? 0 : 90;
         joint_target[j] = joint_start[j];
         joint_elapsed[j] = '0;
         joint_dur[j] = '0;
      end
      mirror_on = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: rest pose, zero duration, angle and time extremes.
      word_queue.push_back(tick_word(0));
      word_queue.push_back(tick_word(1023));
      word_queue.push_back(move_word(-180, 360, 0, 0));
      word_queue.push_back(tick_word(0));
      word_queue.push_back(move_word(-512, 511, 180, 1000));
      word_queue.push_back(tick_word(0));
      word_queue.push_back(tick_word(1));
      word_queue.push_back(tick_word(500));
      word_queue.push_back(tick_word(498));
      word_queue.push_back(tick_word(1));
      word_queue.push_back(tick_word(1000));
      word_queue.push_back(move_word(360, -180, -1, 65535));
      word_queue.push_back(tick_word(1000));
      word_queue.push_back(tick_word(1023));
      word_queue.push_back(move_word(0, 0, 0, 1));
      word_queue.push_back(tick_word(0));
      word_queue.push_back(tick_word(1));
      word_queue.push_back(move_word(-1, 170, 90, 3));
      word_queue.push_back(tick_word(2));
      word_queue.push_back(tick_word(5));
      wait_idle();

      // Random phases over mirror settings; one phase without any idling.
      write_mirror(1'b1);
      random_phase(330);
      wait_idle();
      write_mirror(1'b0);
      idle_on = 1'b0;
      random_phase(330);
      wait_idle();
      idle_on = 1'b1;
      write_mirror(1'b1);
      random_phase(330);
      wait_idle();
      write_mirror(1'b0);
      random_phase(330);
      wait_idle();

      $display("Covered %0d moves and %0d checked ticks across both mirror settings.",
               moves_sent, ticks_checked);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Watchdog
   initial begin
      #5000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

### filelist.f
+incdir+rtl
rtl/smi_pkg.sv
rtl/smi_front.sv
rtl/smi_div.sv
rtl/smi_back.sv
rtl/servo_move_interpolator.sv
dv/testbench.sv
